FILE: rtl/core/ptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the pressure and temperature compensation.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_C  = 3'd3;

  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_FULL  = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [63:0] CAL_BIAS    = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic        valid;
    logic        invalid;
    logic [31:0] centi;
    logic [31:0] fine;
  } ptc_side_t;

  function automatic logic [63:0] sext16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

endpackage

FILE: rtl/core/ptc_mul64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_mul64
// Two-stage 64 x 64 multiplier, low 64 bits of the product (wrapping).
// ----------------------------------------------------------------------------
module ptc_mul64 (
  input  logic        clk,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    ll_r <= {32'b0, a_i[31:0]} * {32'b0, b_i[31:0]};
    lh_r <= a_i[31:0] * b_i[63:32];
    hl_r <= a_i[63:32] * b_i[31:0];
    p_r  <= ll_r + {lh_r + hl_r, 32'b0};
  end

  assign p_o = p_r;

endmodule

FILE: rtl/core/ptc_temp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_temp
// Five-stage 32-bit temperature compensation: fine value and centidegrees.
// ----------------------------------------------------------------------------
module ptc_temp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vld_i,
  input  logic [19:0] adc_t_i,
  input  logic [19:0] adc_p_i,
  input  logic [47:0] temp_cal_i,
  output logic        vld_o,
  output logic [31:0] fine_o,
  output logic [31:0] centi_o,
  output logic [19:0] adc_p_o
);

  localparam int unsigned DEPTH = 5;

  logic        vld_r [1:DEPTH];
  logic [19:0] adcp_r [1:DEPTH];
  logic [19:0] adc_t_r;
  logic [31:0] m1_r;
  logic [31:0] sq_r;
  logic [31:0] a1_r;
  logic [31:0] m3_r;
  logic [31:0] fine_r [4:DEPTH];
  logic [31:0] centi_r;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;
  logic [31:0] d1;
  logic [31:0] d2;
  logic [31:0] sq_sh;
  logic [31:0] f5;

  assign t1 = {16'b0, temp_cal_i[15:0]};
  assign t2 = {{16{temp_cal_i[31]}}, temp_cal_i[31:16]};
  assign t3 = {{16{temp_cal_i[47]}}, temp_cal_i[47:32]};
  assign d1 = {15'b0, adc_t_r[19:3]} - {15'b0, temp_cal_i[15:0], 1'b0};
  assign d2 = {16'b0, adc_t_r[19:4]} - t1;
  assign sq_sh = 32'($signed(sq_r) >>> 12);
  assign f5 = {fine_r[4][29:0], 2'b0} + fine_r[4] + 32'd128;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= DEPTH; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[1] <= vld_i;
      for (int k = 2; k <= DEPTH; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    adc_t_r   <= adc_t_i;
    adcp_r[1] <= adc_p_i;
    for (int k = 2; k <= DEPTH; k++) adcp_r[k] <= adcp_r[k-1];
    m1_r      <= d1 * t2;
    sq_r      <= d2 * d2;
    a1_r      <= 32'($signed(m1_r) >>> 11);
    m3_r      <= sq_sh * t3;
    fine_r[4] <= a1_r + 32'($signed(m3_r) >>> 14);
    fine_r[5] <= fine_r[4];
    centi_r   <= 32'($signed(f5) >>> 8);
  end

  assign vld_o   = vld_r[DEPTH];
  assign fine_o  = fine_r[DEPTH];
  assign centi_o = centi_r;
  assign adc_p_o = adcp_r[DEPTH];

  a_temp_lat : assert property (@(posedge clk) disable iff (!rst_n)
    vld_o |-> $past(vld_i, DEPTH))
    else $error("temperature word without matching entry");

endmodule

FILE: rtl/core/ptc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_divider
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module ptc_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        num_i,
  input  logic [63:0]        den_i,
  input  ptc_pkg::ptc_side_t side_i,
  output logic [63:0]        quo_o,
  output ptc_pkg::ptc_side_t side_o
);

  localparam int unsigned BITS = 64;

  logic [63:0]        rem_r  [0:BITS-1];
  logic [63:0]        nq_r   [0:BITS];
  logic [63:0]        d_r    [0:BITS-1];
  logic               neg_r  [0:BITS];
  ptc_pkg::ptc_side_t side_r [0:BITS];
  logic [63:0]        quo_r;
  ptc_pkg::ptc_side_t out_r;
  ptc_pkg::ptc_side_t side0_nxt;

  always_comb begin
    side0_nxt = side_i;
    side0_nxt.invalid = (den_i == 64'd0);
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= 64'd0;
    nq_r[0]  <= num_i[63] ? 64'd0 - num_i : num_i;
    d_r[0]   <= den_i[63] ? 64'd0 - den_i : den_i;
    neg_r[0] <= num_i[63] ^ den_i[63];
    quo_r    <= neg_r[BITS] ? 64'd0 - nq_r[BITS] : nq_r[BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0] <= '0;
      out_r     <= '0;
    end else begin
      side_r[0] <= side0_nxt;
      out_r     <= side_r[BITS];
    end
  end

  for (genvar k = 0; k < BITS; k++) begin : g_stage
    logic [64:0] trial;
    logic        ge;

    assign trial = {rem_r[k], nq_r[k][63]};
    assign ge    = (trial >= {1'b0, d_r[k]});

    always_ff @(posedge clk) begin
      nq_r[k+1]  <= {nq_r[k][62:0], ge};
      neg_r[k+1] <= neg_r[k];
    end

    if (k < BITS - 1) begin : g_rem
      logic [63:0] diff;

      assign diff = trial[63:0] - d_r[k];

      always_ff @(posedge clk) begin
        rem_r[k+1] <= ge ? diff : trial[63:0];
        d_r[k+1]   <= d_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k+1] <= '0;
      end else begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign quo_o  = quo_r;
  assign side_o = out_r;

  a_div_lat : assert property (@(posedge clk) disable iff (!rst_n)
    side_o.valid |-> $past(side_i.valid, BITS + 2))
    else $error("divider word without matching entry");

  a_div_zero : assert property (@(posedge clk) disable iff (!rst_n)
    side_r[0].valid |-> (side_r[0].invalid == ($past(den_i) == 64'd0)))
    else $error("zero divisor flag lost");

endmodule

FILE: rtl/core/pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Throughput: one word per cycle; busy stays low, start is taken every cycle.
// The 64-stage divider, one quotient bit per stage, sets most of the latency.
// Reset (rst_n low, synchronous) drops all words in flight and clears the
// calibration registers to zero. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module pressure_temp_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [19:0]                    in_pressure_raw,
  input  logic [19:0]                    in_temperature_raw,
  input  logic                           cfg_wr_en,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output logic signed [31:0]             out_temperature_centi,
  output logic signed [31:0]             out_fine_temperature,
  output logic [31:0]                    out_pressure_q24_8,
  output logic                           out_pressure_invalid
);

  localparam int unsigned LAT = 87;

  logic [47:0] temp_cal_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_c_r;

  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  logic        in_accept;
  logic        t_vld;
  logic [31:0] t_fine;
  logic [31:0] t_centi;
  logic [19:0] t_adcp;

  ptc_pkg::ptc_side_t side_r [1:10];
  logic [19:0]        adcp_r [1:6];
  logic [63:0]        v1_r;
  logic [63:0]        sq64, m5, m2, v2a, m3p, prod1, prod2;
  logic [63:0]        m5_d_r [1:2];
  logic [63:0]        m2_d_r [1:2];
  logic [63:0]        v2_r, v1b_r, v1s_r, nd_r, v1c_r, num_r;
  logic [63:0]        p0;

  logic [63:0]        quo;
  ptc_pkg::ptc_side_t dside;
  ptc_pkg::ptc_side_t post_r [1:5];
  logic [63:0]        q_r [1:4];
  logic [63:0]        e2_r [1:2];
  logic [63:0]        ps, psq, e2m, e1m;
  logic [63:0]        sum_r;
  logic [63:0]        pf;

  logic        out_valid_r;
  logic [31:0] out_centi_r;
  logic [31:0] out_fine_r;
  logic [31:0] out_press_r;
  logic        out_inv_r;
  logic [31:0] press_nxt;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      press_c_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ptc_pkg::REG_TEMP_CAL: temp_cal_r <= cfg_data[47:0];
        ptc_pkg::REG_PRESS_A:  press_a_r  <= cfg_data;
        ptc_pkg::REG_PRESS_B:  press_b_r  <= cfg_data;
        ptc_pkg::REG_PRESS_C:  press_c_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign p1 = {48'b0, press_a_r[15:0]};
  assign p2 = ptc_pkg::sext16(press_a_r[31:16]);
  assign p3 = ptc_pkg::sext16(press_a_r[47:32]);
  assign p4 = ptc_pkg::sext16(press_a_r[63:48]);
  assign p5 = ptc_pkg::sext16(press_b_r[15:0]);
  assign p6 = ptc_pkg::sext16(press_b_r[31:16]);
  assign p7 = ptc_pkg::sext16(press_b_r[47:32]);
  assign p8 = ptc_pkg::sext16(press_b_r[63:48]);
  assign p9 = ptc_pkg::sext16(press_c_r);

  ptc_temp u_temp (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (in_accept),
    .adc_t_i    (in_temperature_raw),
    .adc_p_i    (in_pressure_raw),
    .temp_cal_i (temp_cal_r),
    .vld_o      (t_vld),
    .fine_o     (t_fine),
    .centi_o    (t_centi),
    .adc_p_o    (t_adcp)
  );

  // side band travels with the pressure words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 10; k++) side_r[k] <= '0;
    end else begin
      side_r[1] <= '{valid: t_vld, invalid: 1'b0, centi: t_centi, fine: t_fine};
      for (int k = 2; k <= 10; k++) side_r[k] <= side_r[k-1];
    end
  end

  assign p0 = ptc_pkg::PRESS_FULL - {44'b0, adcp_r[6]};

  always_ff @(posedge clk) begin
    adcp_r[1] <= t_adcp;
    for (int k = 2; k <= 6; k++) adcp_r[k] <= adcp_r[k-1];
    v1_r      <= {{32{t_fine[31]}}, t_fine} - ptc_pkg::FINE_OFFSET;
    m5_d_r[1] <= m5;
    m5_d_r[2] <= m5_d_r[1];
    m2_d_r[1] <= m2;
    m2_d_r[2] <= m2_d_r[1];
    v2_r      <= v2a + (m5_d_r[2] << 17) + (p4 << 35);
    v1b_r     <= 64'($signed(m3p) >>> 8) + (m2_d_r[2] << 12);
    v1s_r     <= ptc_pkg::CAL_BIAS + v1b_r;
    nd_r      <= (p0 << 31) - v2_r;
    v1c_r     <= 64'($signed(prod1) >>> 33);
    num_r     <= prod2;
  end

  ptc_mul64 u_mul_sq  (.clk(clk), .a_i(v1_r),  .b_i(v1_r), .p_o(sq64));
  ptc_mul64 u_mul_p5  (.clk(clk), .a_i(v1_r),  .b_i(p5),   .p_o(m5));
  ptc_mul64 u_mul_p2  (.clk(clk), .a_i(v1_r),  .b_i(p2),   .p_o(m2));
  ptc_mul64 u_mul_p6  (.clk(clk), .a_i(sq64),  .b_i(p6),   .p_o(v2a));
  ptc_mul64 u_mul_p3  (.clk(clk), .a_i(sq64),  .b_i(p3),   .p_o(m3p));
  ptc_mul64 u_mul_p1  (.clk(clk), .a_i(v1s_r), .b_i(p1),   .p_o(prod1));
  ptc_mul64 u_mul_num (.clk(clk), .a_i(nd_r),  .b_i(ptc_pkg::PRESS_SCALE), .p_o(prod2));

  ptc_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .num_i  (num_r),
    .den_i  (v1c_r),
    .side_i (side_r[10]),
    .quo_o  (quo),
    .side_o (dside)
  );

  assign ps = 64'($signed(quo) >>> 13);

  ptc_mul64 u_mul_ps (.clk(clk), .a_i(ps),  .b_i(ps), .p_o(psq));
  ptc_mul64 u_mul_p8 (.clk(clk), .a_i(quo), .b_i(p8), .p_o(e2m));
  ptc_mul64 u_mul_p9 (.clk(clk), .a_i(psq), .b_i(p9), .p_o(e1m));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 5; k++) post_r[k] <= '0;
    end else begin
      post_r[1] <= dside;
      for (int k = 2; k <= 5; k++) post_r[k] <= post_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    q_r[1]  <= quo;
    for (int k = 2; k <= 4; k++) q_r[k] <= q_r[k-1];
    e2_r[1] <= e2m;
    e2_r[2] <= e2_r[1];
    sum_r   <= q_r[4] + 64'($signed(e1m) >>> 25) + 64'($signed(e2_r[2]) >>> 19);
  end

  assign pf = 64'($signed(sum_r) >>> 8) + (p7 << 4);

  always_comb begin
    if (post_r[5].invalid || pf[63]) begin
      press_nxt = 32'd0;
    end else if (|pf[62:32]) begin
      press_nxt = 32'hFFFF_FFFF;
    end else begin
      press_nxt = pf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= post_r[5].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_centi_r <= post_r[5].centi;
    out_fine_r  <= post_r[5].fine;
    out_press_r <= press_nxt;
    out_inv_r   <= post_r[5].invalid;
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_centi_r;
  assign out_fine_temperature  = out_fine_r;
  assign out_pressure_q24_8    = out_press_r;
  assign out_pressure_invalid  = out_inv_r;

  a_top_lat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LAT))
    else $error("result word without matching start");

endmodule

FILE: sim/ptc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_checker
// Watches the sample, calibration and result ports of the compensation block,
// predicts each result from its own copy of the calibration words and
// compares every result word field by field, in order.
// ----------------------------------------------------------------------------
module ptc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [19:0]                    in_pressure_raw,
  input  logic [19:0]                    in_temperature_raw,
  input  logic                           cfg_wr_en,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           out_valid,
  input  logic signed [31:0]             out_temperature_centi,
  input  logic signed [31:0]             out_fine_temperature,
  input  logic [31:0]                    out_pressure_q24_8,
  input  logic                           out_pressure_invalid,
  output int                             fail_count,
  output int                             pending_count
);

  typedef struct packed {
    logic [31:0] centi;
    logic [31:0] fine;
    logic [31:0] press;
    logic        invalid;
  } comp_word_t;

  logic [47:0] t_cal;
  logic [63:0] p_cal_a;
  logic [63:0] p_cal_b;
  logic [15:0] p_cal_c;
  comp_word_t  expected_words[$];

  function automatic logic signed [63:0] s16(input logic [63:0] w, input int pos);
    logic [15:0] v;
    v = w[pos +: 16];
    return {{48{v[15]}}, v};
  endfunction

  function automatic comp_word_t compensate(input logic [19:0] adc_p,
                                            input logic [19:0] adc_t);
    comp_word_t r;
    logic signed [31:0] t1, t2, t3, d1, d2, a1, a2, fine;
    logic signed [63:0] v1, v2, p, ps, e1, e2, num;
    logic [63:0] ma, mb, q;
    t1 = {16'd0, t_cal[15:0]};
    t2 = 32'(s16({16'd0, t_cal}, 16));
    t3 = 32'(s16({16'd0, t_cal}, 32));
    d1 = $signed({15'd0, adc_t[19:3]}) - (t1 <<< 1);
    a1 = (d1 * t2) >>> 11;
    d2 = $signed({16'd0, adc_t[19:4]}) - t1;
    a2 = (((d2 * d2) >>> 12) * t3) >>> 14;
    fine = a1 + a2;
    r.fine = fine;
    r.centi = (fine * 32'sd5 + 32'sd128) >>> 8;
    v1 = {{32{fine[31]}}, fine} - 64'sd128000;
    v2 = v1 * v1 * s16(p_cal_b, 16);
    v2 = v2 + ((v1 * s16(p_cal_b, 0)) <<< 17);
    v2 = v2 + (s16(p_cal_a, 48) <<< 35);
    v1 = ((v1 * v1 * s16(p_cal_a, 32)) >>> 8) + ((v1 * s16(p_cal_a, 16)) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * $signed({48'd0, p_cal_a[15:0]})) >>> 33;
    r.press = '0;
    r.invalid = (v1 == 0);
    if (v1 != 0) begin
      p = 64'sd1048576 - $signed({44'd0, adc_p});
      num = ((p <<< 31) - v2) * 64'sd3125;
      ma = num[63] ? -num : num;
      mb = v1[63] ? -v1 : v1;
      q = ma / mb;
      p = (num[63] != v1[63]) ? -q : q;
      ps = p >>> 13;
      e1 = (s16({48'd0, p_cal_c}, 0) * ps * ps) >>> 25;
      e2 = (s16(p_cal_b, 48) * p) >>> 19;
      p = ((p + e1 + e2) >>> 8) + (s16(p_cal_b, 32) <<< 4);
      if (p < 0) r.press = '0;
      else if (p > 64'sd4294967295) r.press = 32'hFFFF_FFFF;
      else r.press = p[31:0];
    end
    return r;
  endfunction

  assign pending_count = expected_words.size();

  always @(posedge clk) begin
    comp_word_t e;
    if (!rst_n) begin
      t_cal <= '0;
      p_cal_a <= '0;
      p_cal_b <= '0;
      p_cal_c <= '0;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (start && !busy) expected_words.push_back(compensate(in_pressure_raw,
                                                              in_temperature_raw));
      if (cfg_wr_en) begin
        case (cfg_index)
          ptc_pkg::REG_TEMP_CAL: t_cal <= cfg_data[47:0];
          ptc_pkg::REG_PRESS_A:  p_cal_a <= cfg_data;
          ptc_pkg::REG_PRESS_B:  p_cal_b <= cfg_data;
          ptc_pkg::REG_PRESS_C:  p_cal_c <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.centi !== out_temperature_centi || e.fine !== out_fine_temperature ||
              e.press !== out_pressure_q24_8 || e.invalid !== out_pressure_invalid) begin
            if (fail_count < 10)
              $display("mismatch: exp c=%0d f=%0d p=%0h i=%0b got c=%0d f=%0d p=%0h i=%0b",
                       $signed(e.centi), $signed(e.fine), e.press, e.invalid,
                       out_temperature_centi, out_fine_temperature,
                       out_pressure_q24_8, out_pressure_invalid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives calibration settings and raw sample pairs into the compensation
// block under varying sender gaps; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [19:0]                    in_pressure_raw = '0;
  logic [19:0]                    in_temperature_raw = '0;
  logic                           cfg_wr_en = 1'b0;
  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           out_valid;
  logic signed [31:0]             out_temperature_centi;
  logic signed [31:0]             out_fine_temperature;
  logic [31:0]                    out_pressure_q24_8;
  logic                           out_pressure_invalid;
  int                             fail_count;
  int                             pending_count;
  int                             cycle_count = 0;
  int                             gap_pct = 0;

  always #5 clk = ~clk;

  pressure_temp_compensation u_top (.*);
  ptc_checker u_check (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("[pressure_temp_compensation] ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic [19:0] pr, input logic [19:0] tr);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_pressure_raw <= pr;
    in_temperature_raw <= tr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_cfg(input logic [ptc_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_cal(input logic [47:0] t, input logic [63:0] a,
                          input logic [63:0] b, input logic [15:0] c);
    put_cfg(ptc_pkg::REG_TEMP_CAL, {16'hFFFF, t});
    put_cfg(ptc_pkg::REG_PRESS_A, a);
    put_cfg(ptc_pkg::REG_PRESS_B, b);
    put_cfg(ptc_pkg::REG_PRESS_C, {48'hFFFF_FFFF_FFFF, c});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic typical_cal();
    logic [15:0] p1;
    p1 = 16'd30000 + 16'($urandom_range(12000));
    load_cal({16'($urandom_range(2000) - 1000), 16'd26000 + 16'($urandom_range(2000)),
              16'd27000 + 16'($urandom_range(2000))},
             {16'($urandom_range(16000) - 8000), 16'($urandom_range(16000) - 8000),
              16'hD000 + 16'($urandom_range(4096)), p1},
             {16'($urandom_range(8000) - 4000), 16'($urandom_range(8000) - 4000),
              16'($urandom_range(200) - 100), 16'($urandom_range(2000) - 1000)},
             16'($urandom_range(12000) - 6000));
  endtask

  initial begin
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_word(20'h80000, 20'h80000);
    drain();
    load_cal({16'hFE0C, 16'd26435, 16'd27504}, {16'd9000, 16'hF9C5, 16'hD4C4, 16'd36477},
             {16'hEEC4, 16'd14000, 16'd140, 16'hFFF9}, 16'd6000);
    send_word(20'd415148, 20'd519888);
    send_word(20'h00000, 20'h00000);
    send_word(20'hFFFFF, 20'hFFFFF);
    send_word(20'hFFFFF, 20'h00000);
    send_word(20'h00000, 20'hFFFFF);
    send_word(20'h55555, 20'hAAAAA);
    drain();
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, '1, '1, 16'h8000);
    send_word(20'h00000, 20'hFFFFF);
    send_word(20'hFFFFF, 20'h00000);
    send_word(20'hAAAAA, 20'h55555);
    drain();
    load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, 64'h8000_8000_8000_0001,
             64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
    send_word(20'h00000, 20'h00000);
    send_word(20'hFFFFF, 20'hFFFFF);
    send_word(20'h12345, 20'h6789A);
    drain();
    for (phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 32 : (phase == 1) ? 77 : 0;
      for (int k = 0; k < 10; k++) begin
        case ($urandom_range(9))
          0: load_cal(48'(rnd64()), rnd64(), rnd64(), 16'($urandom));
          1: load_cal(48'(rnd64()), {rnd64() & 64'hFFFF_FFFF_FFFF_0000}, rnd64(),
                      16'($urandom));
          default: typical_cal();
        endcase
        for (int j = 0; j < 20; j++) begin
          if ($urandom_range(3) == 0)
            send_word(20'($urandom), 20'($urandom));
          else
            send_word(20'd250000 + 20'($urandom_range(300000)),
                      20'd470000 + 20'($urandom_range(80000)));
        end
        drain();
      end
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[pressure_temp_compensation] OK");
    end else begin
      $display("[pressure_temp_compensation] ERROR");
    end
    $finish;
  end
endmodule
